/* rtl/pcl_pkg.sv */
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types, phase codes and helpers for the pc-to-line table lookup.
// ----------------------------------------------------------------------------
package pcl_pkg;

  // Packed op coding
  localparam int FIRST_PACKED_OP = 1;
  localparam int LINE_STEP_RANGE = 5;
  localparam int LINE_STEP_BASE  = -1;

  // Reciprocal for the divide of an 8-bit op by LINE_STEP_RANGE (exact over 0..255)
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + LINE_STEP_RANGE - 1) / LINE_STEP_RANGE;

  localparam logic [2:0] LEB_MAX_BYTES = 3'd5;
  localparam logic [31:0] PC_ALL_ONES  = 32'hFFFF_FFFF;

  // Parse phases
  localparam logic [2:0] PH_HDR_LINE   = 3'd0;
  localparam logic [2:0] PH_HDR_COL    = 3'd1;
  localparam logic [2:0] PH_OP         = 3'd2;
  localparam logic [2:0] PH_PC_DELTA   = 3'd3;
  localparam logic [2:0] PH_LINE_DELTA = 3'd4;
  localparam logic [2:0] PH_COL_DELTA  = 3'd5;

  typedef struct packed {
    logic [2:0]  parse_phase;
    logic [31:0] value_accumulator;
    logic [2:0]  value_byte_count;
    logic [31:0] current_pc;
    logic [31:0] current_line;
    logic [31:0] current_column;
    logic [31:0] pending_line;
    logic        answer_given;
  } state_t;

  // All fields zero; phase zero is the header line phase
  localparam state_t STATE_CLEAR = '{default: '0};

  typedef struct packed {
    logic signed [31:0] line_number;
    logic signed [31:0] column_number;
    logic               status;
  } result_t;

  function automatic logic [31:0] unzigzag(input logic [31:0] v);
    unzigzag = (v >> 1) ^ {32{v[0]}};
  endfunction

  // Bit position of a LEB128 group: 7 * count, mod 32
  function automatic logic [4:0] leb_shift(input logic [2:0] cnt);
    logic [5:0] p;
    p = 6'(cnt) * 6'd7;
    leb_shift = p[4:0];
  endfunction

endpackage

/* rtl/pcl_in_if.sv */
// ----------------------------------------------------------------------------
// pcl_in_if
// Table byte channel: valid/ready with one byte and an end-of-table mark.
// ----------------------------------------------------------------------------
interface pcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       final_byte;

  modport source (output valid, output table_byte, output final_byte, input ready);
  modport sink   (input valid, input table_byte, input final_byte, output ready);
endinterface

/* rtl/pcl_out_if.sv */
// ----------------------------------------------------------------------------
// pcl_out_if
// Lookup result channel: valid/ready with line, column and status.
// ----------------------------------------------------------------------------
interface pcl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] line_number;
  logic signed [31:0] column_number;
  logic               status;

  modport source (output valid, output line_number, output column_number, output status,
                  input ready);
  modport sink   (input valid, input line_number, input column_number, input status,
                  output ready);
endinterface

/* rtl/pc_to_line_table_lookup_unit.sv */
// ----------------------------------------------------------------------------
// pc_to_line_table_lookup_unit
// Streaming line-table decoder: finds the line and column for target_pc.
// ----------------------------------------------------------------------------
// Takes one table byte per cycle, back to back, with no gaps between tables.
// A byte is registered on acceptance and decoded from that register by a
// combinational parse step; the result word it produces is registered when
// that step is taken and is held until results.ready takes it.
// Input stalls only while a result word waits on results.ready and the byte
// being decoded produces another one. Each table (ended by a byte with
// final_byte set) yields exactly one result word: the line and column in force
// when the pc passes target_pc, at table end, or right after the header if
// target_pc is all ones; status 1 with zero line and column flags a truncated
// or overlong value. target_pc must only be written while no table is in
// progress.
module pc_to_line_table_lookup_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  pcl_in_if.sink      bytes,
  pcl_out_if.source   results
);
  import pcl_pkg::*;

  logic [31:0] target_pc;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  state_t      st;
  state_t      st_next;
  logic        emit;
  result_t     step_res;
  logic        proc;

  logic        out_valid;
  result_t     out_res;

  pcl_step u_step (
    .st         (st),
    .table_byte (s1_byte),
    .final_byte (s1_last),
    .target_pc  (target_pc),
    .st_next    (st_next),
    .emit       (emit),
    .result     (step_res)
  );

  // Decode stalls only when it has a word to load and the result register is held
  assign proc        = s1_valid && (!out_valid || results.ready || !emit);
  assign bytes.ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pc <= '0;
    end else if (cfg_wr_en) begin
      target_pc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.table_byte;
      s1_last <= bytes.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (proc) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_res <= step_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.line_number   = out_res.line_number;
  assign results.column_number = out_res.column_number;
  assign results.status        = out_res.status;

  // Error words always carry zero line and column
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status |-> out_res.line_number == '0 && out_res.column_number == '0)
    else $error("error word with nonzero line or column");

  // End of table returns the parser to its clean state
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> st.parse_phase == PH_HDR_LINE && !st.answer_given &&
                        st.current_pc == '0 && st.value_byte_count == '0)
    else $error("parser not cleared after final byte");

  // Once answered, the rest of the table produces nothing
  a_no_second_answer: assert property (@(posedge clk) disable iff (rst)
    proc && st.answer_given |-> !emit)
    else $error("second result within one table");

  // A new result word only follows a decode step
  a_word_from_step: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(proc && emit))
    else $error("result word without decode step");

  // LEB byte count never passes the overlong limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    st.value_byte_count <= LEB_MAX_BYTES)
    else $error("LEB byte count out of range");

endmodule

/* rtl/pcl_step.sv */
// ----------------------------------------------------------------------------
// pcl_step
// Single-byte parse step: next decoder state and the optional result word.
// ----------------------------------------------------------------------------
module pcl_step (
  input  pcl_pkg::state_t  st,
  input  logic [7:0]       table_byte,
  input  logic             final_byte,
  input  logic [31:0]      target_pc,
  output pcl_pkg::state_t  st_next,
  output logic             emit,
  output pcl_pkg::result_t result
);
  import pcl_pkg::*;

  logic [7:0]  op;
  logic [24:0] prod;
  logic [7:0]  pc_step;
  logic [15:0] qd;
  logic [7:0]  line_rem;
  logic [31:0] acc_or;
  logic [2:0]  cnt_inc;
  state_t      nxt;
  logic        hit;
  result_t     res;

  // op / LINE_STEP_RANGE via reciprocal multiply, remainder by back-multiply
  assign op       = 8'(table_byte - 8'(FIRST_PACKED_OP));
  assign prod     = {17'b0, op} * 25'(RECIP);
  assign pc_step  = prod[RECIP_SHIFT +: 8];
  assign qd       = 16'(pc_step) * 16'(LINE_STEP_RANGE);
  assign line_rem = 8'(16'(op) - qd);

  assign acc_or  = st.value_accumulator | ({25'b0, table_byte[6:0]} << leb_shift(st.value_byte_count));
  assign cnt_inc = st.value_byte_count + 3'd1;

  always_comb begin
    nxt = st;
    hit = 1'b0;
    res = '{line_number: '0, column_number: '0, status: 1'b1};

    if (st.parse_phase == PH_OP) begin
      nxt.value_accumulator = '0;
      nxt.value_byte_count  = '0;
      if (table_byte == 8'd0) begin
        nxt.parse_phase = PH_PC_DELTA;
      end else begin
        nxt.current_pc   = st.current_pc + 32'(pc_step);
        nxt.pending_line = st.current_line + 32'(line_rem) + 32'(LINE_STEP_BASE);
        nxt.parse_phase  = PH_COL_DELTA;
      end
      hit = final_byte;
    end else if (st.parse_phase > PH_COL_DELTA) begin
      hit = 1'b1;
    end else begin
      nxt.value_accumulator = acc_or;
      nxt.value_byte_count  = cnt_inc;
      if (table_byte[7]) begin
        hit = (cnt_inc >= LEB_MAX_BYTES) || final_byte;
      end else begin
        nxt.value_accumulator = '0;
        nxt.value_byte_count  = '0;
        case (st.parse_phase)
          PH_HDR_LINE: begin
            nxt.current_line = acc_or + 32'd1;
            nxt.parse_phase  = PH_HDR_COL;
            hit = final_byte;
          end
          PH_HDR_COL: begin
            nxt.current_column = acc_or + 32'd1;
            nxt.parse_phase    = PH_OP;
            if (target_pc == PC_ALL_ONES || final_byte) begin
              hit = 1'b1;
              res = '{line_number: st.current_line, column_number: acc_or + 32'd1,
                      status: 1'b0};
            end
          end
          PH_PC_DELTA: begin
            nxt.current_pc  = st.current_pc + acc_or;
            nxt.parse_phase = PH_LINE_DELTA;
            hit = final_byte;
          end
          PH_LINE_DELTA: begin
            nxt.pending_line = st.current_line + unzigzag(acc_or);
            nxt.parse_phase  = PH_COL_DELTA;
            hit = final_byte;
          end
          default: begin
            if (target_pc < st.current_pc) begin
              // pc has passed the target: report what was in force before this entry
              hit = 1'b1;
              res = '{line_number: st.current_line, column_number: st.current_column,
                      status: 1'b0};
            end else begin
              nxt.current_line   = st.pending_line;
              nxt.current_column = st.current_column + unzigzag(acc_or);
              nxt.parse_phase    = PH_OP;
              if (final_byte) begin
                hit = 1'b1;
                res = '{line_number: st.pending_line,
                        column_number: st.current_column + unzigzag(acc_or),
                        status: 1'b0};
              end
            end
          end
        endcase
      end
    end

    if (st.answer_given) begin
      nxt = st;
      hit = 1'b0;
    end
    if (final_byte) begin
      nxt = STATE_CLEAR;
    end else if (hit) begin
      nxt.answer_given = 1'b1;
    end
  end

  assign st_next = nxt;
  assign emit    = hit;
  assign result  = res;

endmodule
